/* hw/rtl/gne_pkg.sv */
// gne_pkg: shared constants, types and index helpers of the gradient noise evaluator
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps
`default_nettype none

package gne_pkg;

   // table geometry
   localparam int TABLE_SIZE = 256;
   localparam int TBITS      = $clog2(TABLE_SIZE);
   localparam int PW         = (TBITS > 8) ? TBITS : 8;

   // item opcodes
   localparam logic [1:0] OP_WR_PERM = 2'd0;
   localparam logic [1:0] OP_WR_GRAD = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;

   // datapath widths
   localparam int FW        = 16;            // fraction, q0.16
   localparam int GW        = 16;            // gradient component, q1.14
   localparam int GRAD3_W   = 3 * GW;
   localparam int TW        = FW + 1;        // signed corner offset
   localparam int PRW       = GW + TW;       // gradient times offset
   localparam int DOT_SHIFT = 14;
   localparam int VW        = 22;            // blended value
   localparam int SW        = VW + DOT_SHIFT;
   localparam int WW        = 18;            // fade weight
   localparam int MW        = VW + 1 + WW + 1;
   localparam int OUT_W     = 20;
   localparam int NSTAGE    = 13;

   localparam logic [WW-1:0] THREE_Q16 = WW'(3 * 65536);
   localparam logic signed [VW-1:0] SAT_HI = VW'(524287);
   localparam logic signed [VW-1:0] SAT_LO = VW'(-524288);

   typedef logic [TBITS-1:0] tidx_type;

   // one pipeline stage
   typedef struct packed {
      logic                          valid;
      logic [1:0]                    op;
      logic [1:0]                    dims;
      tidx_type                      idx;
      logic [7:0]                    perm_value;
      logic [GRAD3_W-1:0]            grad;
      logic [2:0][FW-1:0]            frac;
      logic [2:0][1:0][TBITS-1:0]    grid;
      logic [2:0][FW-1:0]            t2;
      logic [2:0][WW-1:0]            w;
      logic [3:0][7:0]               h;
      logic [23:0][PRW-1:0]          prod;
      logic [7:0][VW-1:0]            dot;
      logic [3:0][MW-1:0]            m;
      logic [3:0][VW-1:0]            ax;
      logic [1:0][VW-1:0]            ay;
      logic [OUT_W-1:0]              vout;
   } pipe_type;

   // permutation value folded to a table index
   function automatic tidx_type to_idx(input logic [7:0] p);
      logic [PW-1:0] s;
      s = PW'(p);
      return s[TBITS-1:0];
   endfunction

   // cell plus permutation value, wrapped to the table
   function automatic tidx_type hash_add(input tidx_type base, input logic [7:0] p);
      logic [PW-1:0] s;
      s = PW'(base) + PW'(p);
      return s[TBITS-1:0];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/gne_ram.sv */
// gne_ram: generic one-write, two-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module gne_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
   output logic [WIDTH-1:0]           rd_data_a,
   output logic [WIDTH-1:0]           rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port and registered reads, read data held while stalled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

/* hw/rtl/gradient_noise_evaluator.sv */
// gradient noise evaluator: 13-stage pipeline, one item per cycle while rsp_ready does not stall it
// the stages hold three chained permutation ram levels, the gradient ram read, the dot product stages
// and three multiply/subtract blend pairs
// reset clears the stage valid bits only; the tables are not cleared and hold unknown
// contents until written
// depends on gne_pkg and gne_ram
`timescale 1ns / 1ps
`default_nettype none

module gradient_noise_evaluator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [7:0]                  req_index,
   input  logic [7:0]                  req_perm_value,
   input  logic signed [15:0]          req_grad_x,
   input  logic signed [15:0]          req_grad_y,
   input  logic signed [15:0]          req_grad_z,
   input  logic [1:0]                  req_dims,
   input  logic signed [31:0]          req_coord_x,
   input  logic signed [31:0]          req_coord_y,
   input  logic signed [31:0]          req_coord_z,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [gne_pkg::OUT_W-1:0] rsp_noise_value
);

   import gne_pkg::*;

   pipe_type           st_ff [NSTAGE];
   pipe_type           st_in [NSTAGE];
   logic [NSTAGE:0]    ld;

   logic [7:0]         l1_rd [2];
   logic [7:0]         l2_rd [4];
   logic [7:0]         l3_rd [8];
   logic [GRAD3_W-1:0] g_rd  [8];
   tidx_type           l2_addr [4];
   tidx_type           l3_addr [8];
   tidx_type           q_addr  [8];

   // first half of a blend: weight times difference
   function automatic logic signed [MW-1:0] blend_mul(input logic signed [VW-1:0] a,
                                                       input logic signed [VW-1:0] b,
                                                       input logic [WW-1:0] w);
      logic signed [VW:0]   d;
      logic signed [MW-1:0] p;
      d = {a[VW-1], a} - {b[VW-1], b};
      p = d * $signed({1'b0, w});
      return p;
   endfunction

   // second half of a blend: a minus the scaled product
   function automatic logic signed [VW-1:0] blend_sub(input logic signed [VW-1:0] a,
                                                       input logic signed [MW-1:0] m);
      logic signed [MW-1:0] s;
      s = MW'(a) - (m >>> 16);
      return s[VW-1:0];
   endfunction

   // load chain: a stage loads when empty or when its item moves on
   always_comb begin
      ld[NSTAGE] = rsp_ready;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         ld[k] = !st_ff[k].valid || ld[k+1];
      end
   end

   assign req_ready = ld[0];

   // stage datapath
   always_comb begin
      logic [31:0]          sq;
      logic [WW-1:0]        kf;
      logic [WW+FW-1:0]     wp;
      logic [GRAD3_W-1:0]   g3;
      logic signed [TW-1:0] tv [3];
      logic signed [GW-1:0] gv;
      logic signed [PRW-1:0] pr;
      logic signed [SW-1:0] s;
      logic signed [VW-1:0] vz;
      logic signed [VW-1:0] sel;

      // stage 0: capture item, split point into cells and fractions
      st_in[0]            = '0;
      st_in[0].valid      = req_valid;
      st_in[0].op         = req_op;
      st_in[0].dims       = (req_dims == 2'd0) ? 2'd1 : req_dims;
      st_in[0].idx        = to_idx(req_index);
      st_in[0].perm_value = req_perm_value;
      st_in[0].grad       = {req_grad_x, req_grad_y, req_grad_z};
      st_in[0].frac[0]    = req_coord_x[FW-1:0];
      st_in[0].frac[1]    = req_coord_y[FW-1:0];
      st_in[0].frac[2]    = req_coord_z[FW-1:0];
      st_in[0].grid[0][0] = req_coord_x[16 +: TBITS];
      st_in[0].grid[1][0] = req_coord_y[16 +: TBITS];
      st_in[0].grid[2][0] = req_coord_z[16 +: TBITS];
      for (int a = 0; a < 3; a++) begin
         st_in[0].grid[a][1] = st_in[0].grid[a][0] + TBITS'(1);
      end

      // stage 1: fraction squared
      st_in[1] = st_ff[0];
      for (int a = 0; a < 3; a++) begin
         sq = st_ff[0].frac[a] * st_ff[0].frac[a];
         st_in[1].t2[a] = sq[31:16];
      end

      // stage 2: fade weight
      st_in[2] = st_ff[1];
      for (int a = 0; a < 3; a++) begin
         kf = THREE_Q16 - WW'({st_ff[1].frac[a], 1'b0});
         wp = kf * st_ff[1].t2[a];
         st_in[2].w[a] = wp[WW+FW-1:FW];
      end

      // stage 3: keep the second level hashes
      st_in[3] = st_ff[2];
      for (int i = 0; i < 4; i++) begin
         st_in[3].h[i] = l2_rd[i];
      end

      // stage 4: only queries go past the tables
      st_in[4]       = st_ff[3];
      st_in[4].valid = st_ff[3].valid && (st_ff[3].op == OP_QUERY);

      // stage 5: gradient times corner offset
      st_in[5] = st_ff[4];
      for (int c = 0; c < 8; c++) begin
         g3    = g_rd[c];
         tv[0] = {((c & 1) != 0), st_ff[4].frac[0]};
         tv[1] = (st_ff[4].dims >= 2'd2) ? {((c & 2) != 0), st_ff[4].frac[1]} : '0;
         tv[2] = (st_ff[4].dims == 2'd3) ? {((c & 4) != 0), st_ff[4].frac[2]} : '0;
         for (int a = 0; a < 3; a++) begin
            gv = g3[(2-a)*GW +: GW];
            pr = gv * tv[a];
            st_in[5].prod[c*3+a] = pr;
         end
      end

      // stage 6: corner dot products
      st_in[6] = st_ff[5];
      for (int c = 0; c < 8; c++) begin
         s = SW'($signed(st_ff[5].prod[c*3])) + SW'($signed(st_ff[5].prod[c*3+1]))
           + SW'($signed(st_ff[5].prod[c*3+2]));
         st_in[6].dot[c] = s[SW-1:DOT_SHIFT];
      end

      // stages 7 and 8: blend along x
      st_in[7] = st_ff[6];
      for (int p = 0; p < 4; p++) begin
         st_in[7].m[p] = blend_mul(st_ff[6].dot[2*p], st_ff[6].dot[2*p+1], st_ff[6].w[0]);
      end
      st_in[8] = st_ff[7];
      for (int p = 0; p < 4; p++) begin
         st_in[8].ax[p] = blend_sub(st_ff[7].dot[2*p], st_ff[7].m[p]);
      end

      // stages 9 and 10: blend along y
      st_in[9] = st_ff[8];
      for (int j = 0; j < 2; j++) begin
         st_in[9].m[j] = blend_mul(st_ff[8].ax[2*j], st_ff[8].ax[2*j+1], st_ff[8].w[1]);
      end
      st_in[10] = st_ff[9];
      for (int j = 0; j < 2; j++) begin
         st_in[10].ay[j] = blend_sub(st_ff[9].ax[2*j], st_ff[9].m[j]);
      end

      // stage 11: z product
      st_in[11]      = st_ff[10];
      st_in[11].m[0] = blend_mul(st_ff[10].ay[0], st_ff[10].ay[1], st_ff[10].w[2]);

      // stage 12: z subtract, pick by dims, saturate
      st_in[12] = st_ff[11];
      vz = blend_sub(st_ff[11].ay[0], st_ff[11].m[0]);
      case (st_ff[11].dims)
         2'd1:    sel = st_ff[11].ax[0];
         2'd2:    sel = st_ff[11].ay[0];
         default: sel = vz;
      endcase
      if (sel > SAT_HI) begin
         sel = SAT_HI;
      end else if (sel < SAT_LO) begin
         sel = SAT_LO;
      end
      st_in[12].vout = sel[OUT_W-1:0];
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTAGE; k++) begin
         if (reset) begin
            st_ff[k].valid <= 1'b0;
         end else if (ld[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // hash and gradient addresses
   always_comb begin
      for (int j = 0; j < 2; j++) begin
         l2_addr[2*j]   = hash_add(st_ff[1].grid[1][j], l1_rd[0]);
         l2_addr[2*j+1] = hash_add(st_ff[1].grid[1][j], l1_rd[1]);
      end
      for (int c = 0; c < 8; c++) begin
         l3_addr[c] = hash_add(st_ff[2].grid[2][c/4], l2_rd[c%4]);
      end
      for (int c = 0; c < 8; c++) begin
         case (st_ff[3].dims)
            2'd1:    q_addr[c] = st_ff[3].grid[0][c%2];
            2'd2:    q_addr[c] = to_idx(st_ff[3].h[c%4]);
            default: q_addr[c] = to_idx(l3_rd[c]);
         endcase
      end
   end

   // permutation level one: x cells
   gne_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm_l1 (
      .clock     (clock),
      .wr_en     (ld[1] && st_ff[0].valid && (st_ff[0].op == OP_WR_PERM)),
      .wr_addr   (st_ff[0].idx),
      .wr_data   (st_ff[0].perm_value),
      .rd_en     (ld[1]),
      .rd_addr_a (st_ff[0].grid[0][0]),
      .rd_addr_b (st_ff[0].grid[0][1]),
      .rd_data_a (l1_rd[0]),
      .rd_data_b (l1_rd[1])
   );

   // permutation level two, one copy per y corner
   for (genvar j = 0; j < 2; j++) begin : g_perm_l2
      gne_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
         .clock     (clock),
         .wr_en     (ld[2] && st_ff[1].valid && (st_ff[1].op == OP_WR_PERM)),
         .wr_addr   (st_ff[1].idx),
         .wr_data   (st_ff[1].perm_value),
         .rd_en     (ld[2]),
         .rd_addr_a (l2_addr[2*j]),
         .rd_addr_b (l2_addr[2*j+1]),
         .rd_data_a (l2_rd[2*j]),
         .rd_data_b (l2_rd[2*j+1])
      );
   end

   // permutation level three, one copy per corner pair
   for (genvar r = 0; r < 4; r++) begin : g_perm_l3
      gne_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
         .clock     (clock),
         .wr_en     (ld[3] && st_ff[2].valid && (st_ff[2].op == OP_WR_PERM)),
         .wr_addr   (st_ff[2].idx),
         .wr_data   (st_ff[2].perm_value),
         .rd_en     (ld[3]),
         .rd_addr_a (l3_addr[2*r]),
         .rd_addr_b (l3_addr[2*r+1]),
         .rd_data_a (l3_rd[2*r]),
         .rd_data_b (l3_rd[2*r+1])
      );
   end

   // gradient triples, one copy per corner pair
   for (genvar r = 0; r < 4; r++) begin : g_grad
      gne_ram #(.WIDTH(GRAD3_W), .DEPTH(TABLE_SIZE)) u_ram (
         .clock     (clock),
         .wr_en     (ld[4] && st_ff[3].valid && (st_ff[3].op == OP_WR_GRAD)),
         .wr_addr   (st_ff[3].idx),
         .wr_data   (st_ff[3].grad),
         .rd_en     (ld[4]),
         .rd_addr_a (q_addr[2*r]),
         .rd_addr_b (q_addr[2*r+1]),
         .rd_data_a (g_rd[2*r]),
         .rd_data_b (g_rd[2*r+1])
      );
   end

   // result channel
   assign rsp_valid       = st_ff[NSTAGE-1].valid;
   assign rsp_noise_value = st_ff[NSTAGE-1].vout;

endmodule

`default_nettype wire

/* hw/rtl/gne_checker.sv */
// gne_checker: port-level assertions for the gradient noise evaluator, and its bind
// depends on gne_pkg; binds to gradient_noise_evaluator
`timescale 1ns / 1ps
`default_nettype none

module gne_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [gne_pkg::OUT_W-1:0]   rsp_noise_value
);

   import gne_pkg::*;

   // a waiting result item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // a waiting result item keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_noise_value))
      else $error("result item changed while stalled");

   // the pipeline only pushes back when the result side is stalled
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a full, stalled output");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item offered right after reset");

endmodule

bind gradient_noise_evaluator gne_checker u_checker (.*);

`default_nettype wire
